// File: hdl/grid_max_path_sum_dp_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the grid path-sum block
// Concurrent checks clocked on clock and disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef GRID_MAX_PATH_SUM_DP_DEFINES_SVH
`define GRID_MAX_PATH_SUM_DP_DEFINES_SVH

// same-cycle implication
`define GMP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GMP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/gmp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gmp_pkg
// Shared constants and types of the grid path-sum block.
// ---------------------------------------------------------------------------
package gmp_pkg;

   // width of the row and column index fields on the result beat
   localparam int IDX_W = 7;

   // width of the grid size register
   localparam int SIZE_W = 8;

   // position flags of one cell, from the sequencer to the datapath
   typedef struct packed {
      logic             first_col;
      logic             has_upper;
      logic             has_lower;
      logic             last_cell;
      logic [IDX_W-1:0] row_idx;
      logic [IDX_W-1:0] col_idx;
   } pos_type;

endpackage

// File: hdl/gmp_ifs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gmp_req_if / gmp_rsp_if
// Valid/ready channels for cell beats and result beats.
// ---------------------------------------------------------------------------
interface gmp_req_if #(
   parameter int VALUE_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] cell_value;

   modport source (output valid, output cell_value, input ready);
   modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmp_rsp_if #(
   parameter int SUM_W = 23
);
   logic                             valid;
   logic                             ready;
   logic signed [SUM_W-1:0]          path_sum;
   logic [gmp_pkg::IDX_W-1:0]        row_index;
   logic [gmp_pkg::IDX_W-1:0]        column_index;
   logic                             last_of_grid;

   modport source (output valid, output path_sum, output row_index,
                   output column_index, output last_of_grid, input ready);
   modport sink   (input valid, input path_sum, input row_index,
                   input column_index, input last_of_grid, output ready);
endinterface

// File: hdl/gmp_column_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gmp_column_mem
// Column sum store: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module gmp_column_mem #(
   parameter int DEPTH = 128,
   parameter int AW    = 7,
   parameter int DW    = 23
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr_a,
   input  logic [AW-1:0]        rd_addr_b,
   output logic signed [DW-1:0] rd_data_a_ff,
   output logic signed [DW-1:0] rd_data_b_ff,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic signed [DW-1:0] wr_data
);

   logic signed [DW-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read ports, old data on a same-cycle write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

endmodule

// File: hdl/gmp_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gmp_sequencer
// Grid size register and row/column counters; issues read addresses.
// ---------------------------------------------------------------------------
module gmp_sequencer #(
   parameter int MAX_N = 128,
   parameter int CW    = 7,
   parameter int AW    = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [gmp_pkg::SIZE_W-1:0]    csr_wr_data,
   input  logic                          req_accept,
   output logic [AW-1:0]                 addr_a,
   output logic [AW-1:0]                 addr_b,
   output gmp_pkg::pos_type              pos
);

   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] last_idx_ff, last_idx_in;
   logic          last_row;
   logic          last_col;
   logic [CW-1:0] row_inc;

   assign last_row = (row_ff == last_idx_ff);
   assign last_col = (col_ff == last_idx_ff);
   assign row_inc  = row_ff + CW'(1);

   // read addresses: this row and the row below
   assign addr_a = row_ff[AW-1:0];
   assign addr_b = AW'(row_inc);

   // position flags for the datapath
   always_comb begin
      pos.first_col = (col_ff == '0);
      pos.has_upper = (row_ff != '0);
      pos.has_lower = !last_row;
      pos.last_cell = last_row && last_col;
      pos.row_idx   = row_ff[gmp_pkg::IDX_W-1:0];
      pos.col_idx   = col_ff[gmp_pkg::IDX_W-1:0];
   end

   // counters and size register
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      last_idx_in = last_idx_ff;
      if (csr_wr_en) begin
         // zero means one, oversize saturates
         if (csr_wr_data == '0) begin
            last_idx_in = '0;
         end else if (int'(csr_wr_data) > MAX_N) begin
            last_idx_in = CW'(MAX_N - 1);
         end else begin
            last_idx_in = CW'(csr_wr_data - 8'd1);
         end
         row_in = '0;
         col_in = '0;
      end else if (req_accept) begin
         if (!last_row) begin
            row_in = row_inc;
         end else begin
            row_in = '0;
            col_in = last_col ? '0 : col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         last_idx_ff <= '0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         last_idx_ff <= last_idx_in;
      end
   end

endmodule

// File: hdl/gmp_datapath.sv
`timescale 1ns / 1ps
`include "grid_max_path_sum_dp_defines.svh"
// ---------------------------------------------------------------------------
// gmp_datapath
// Read-modify-write stage with forwarding, upper-row save and result register.
// ---------------------------------------------------------------------------
module gmp_datapath #(
   parameter int VALUE_BITS = 16,
   parameter int SUM_W      = 23,
   parameter int AW         = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   // cell beats
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [VALUE_BITS-1:0]  req_cell_value,
   output logic                          req_accept,
   // position of the cell at the head of the request channel
   input  gmp_pkg::pos_type              pos,
   input  logic [AW-1:0]                 addr_a,
   input  logic [AW-1:0]                 addr_b,
   // column store
   input  logic signed [SUM_W-1:0]       rd_data_a,
   input  logic signed [SUM_W-1:0]       rd_data_b,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output logic signed [SUM_W-1:0]       wr_data,
   // result beats
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SUM_W-1:0]       rsp_path_sum,
   output logic [gmp_pkg::IDX_W-1:0]     rsp_row_index,
   output logic [gmp_pkg::IDX_W-1:0]     rsp_column_index,
   output logic                          rsp_last_of_grid
);

   // stage 1: cell waiting on its memory read
   logic                          s1_valid_ff, s1_valid_in;
   gmp_pkg::pos_type              s1_pos_ff;
   logic signed [VALUE_BITS-1:0]  s1_cell_ff;
   logic [AW-1:0]                 s1_addr_a_ff;
   logic [AW-1:0]                 s1_addr_b_ff;
   logic                          s1_adv;

   // write that landed on the same edge as the read
   logic                          fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]                 fwd_addr_ff;
   logic signed [SUM_W-1:0]       fwd_data_ff;

   // previous-column sum of the row above
   logic signed [SUM_W-1:0]       saved_ff, saved_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0]       rsp_sum_ff;
   logic [gmp_pkg::IDX_W-1:0]     rsp_row_ff;
   logic [gmp_pkg::IDX_W-1:0]     rsp_col_ff;
   logic                          rsp_last_ff;

   logic signed [SUM_W-1:0]       left_sum;
   logic signed [SUM_W-1:0]       lower_sum;
   logic signed [SUM_W-1:0]       best_sum;
   logic signed [SUM_W-1:0]       cell_ext;
   logic signed [SUM_W-1:0]       new_sum;

   // handshake
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign req_accept = req_valid && req_ready;

   // predecessor select and add
   always_comb begin
      left_sum  = (fwd_valid_ff && (fwd_addr_ff == s1_addr_a_ff)) ? fwd_data_ff : rd_data_a;
      lower_sum = (fwd_valid_ff && (fwd_addr_ff == s1_addr_b_ff)) ? fwd_data_ff : rd_data_b;
      best_sum  = left_sum;
      if (s1_pos_ff.has_upper && (saved_ff > best_sum)) begin
         best_sum = saved_ff;
      end
      if (s1_pos_ff.has_lower && (lower_sum > best_sum)) begin
         best_sum = lower_sum;
      end
      cell_ext = SUM_W'(s1_cell_ff);
      new_sum  = s1_pos_ff.first_col ? cell_ext : best_sum + cell_ext;
   end

   // write back in place
   assign wr_en   = s1_adv;
   assign wr_addr = s1_addr_a_ff;
   assign wr_data = new_sum;

   // control next state
   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_adv);
      fwd_valid_in = req_accept ? wr_en : fwd_valid_ff;
      saved_in     = s1_adv ? left_sum : saved_ff;
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         saved_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         saved_ff     <= saved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pos_ff    <= pos;
         s1_cell_ff   <= req_cell_value;
         s1_addr_a_ff <= addr_a;
         s1_addr_b_ff <= addr_b;
         fwd_addr_ff  <= wr_addr;
         fwd_data_ff  <= wr_data;
      end
      if (s1_adv) begin
         rsp_sum_ff  <= new_sum;
         rsp_row_ff  <= s1_pos_ff.row_idx;
         rsp_col_ff  <= s1_pos_ff.col_idx;
         rsp_last_ff <= s1_pos_ff.last_cell;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_path_sum     = rsp_sum_ff;
   assign rsp_row_index    = rsp_row_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_last_of_grid = rsp_last_ff;

   // checks
   `GMP_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !s1_adv,
      s1_valid_ff && $stable(s1_addr_a_ff), "stalled stage 1 lost its cell")
   `GMP_ASSERT_NEXT(a_rsp_load, s1_adv, rsp_valid_ff && (rsp_sum_ff == $past(new_sum)),
      "result register missed an advancing cell")
   `GMP_ASSERT_NEXT(a_fwd_capture, req_accept && wr_en,
      fwd_valid_ff && (fwd_addr_ff == $past(s1_addr_a_ff)),
      "same-edge write not captured for forwarding")

endmodule

// File: hdl/grid_max_path_sum_dp.sv
`timescale 1ns / 1ps
// Usage:
//   req_bus carries one grid cell per beat (cell_value), column by column,
//   top row first. rsp_bus returns one beat per cell: the best path sum that
//   ends in that cell, its row and column, and last_of_grid on the final cell.
//   csr_wr_en / csr_wr_data write the grid size (0 acts as 1, sizes above
//   MAX_N saturate); a write also restarts at row 0, column 0. Write it only
//   while the block is idle.
//   A cell goes through the read stage and the result register to rsp_bus.
//   Throughput: one cell per cycle while rsp_bus does not stall, set by the
//   column store, which does one read of two rows and one write per cycle;
//   a write landing on the same edge as a read is forwarded from a register.
//   Reset (synchronous, active high) empties the pipeline, sets the grid size
//   to 1 and the position to row 0, column 0. The column store needs no
//   clearing pass: every read after column 0 hits a row the previous column
//   wrote.
//   When rsp_bus stalls, the result register holds its beat and the read
//   stage keeps one more cell; once both are full, req_bus.ready is low in
//   the same cycle as rsp_bus.ready.
// ---------------------------------------------------------------------------
// grid_max_path_sum_dp
// Maximum-sum left-to-right path over a square grid, one cell per beat.
// ---------------------------------------------------------------------------
module grid_max_path_sum_dp #(
   parameter int MAX_N      = 128,
   parameter int VALUE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   gmp_req_if.sink                     req_bus,
   gmp_rsp_if.source                   rsp_bus,
   input  logic                        csr_wr_en,
   input  logic [gmp_pkg::SIZE_W-1:0]  csr_wr_data
);

   localparam int LOG_N = $clog2(MAX_N);
   localparam int AW    = (LOG_N > 0) ? LOG_N : 1;
   localparam int CW    = (LOG_N > gmp_pkg::IDX_W) ? LOG_N : gmp_pkg::IDX_W;
   localparam int SUM_W = VALUE_BITS + LOG_N;

   logic                    req_accept;
   logic [AW-1:0]           addr_a;
   logic [AW-1:0]           addr_b;
   gmp_pkg::pos_type        pos;
   logic signed [SUM_W-1:0] rd_data_a;
   logic signed [SUM_W-1:0] rd_data_b;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic signed [SUM_W-1:0] wr_data;

   // position counters and size register
   gmp_sequencer #(
      .MAX_N (MAX_N),
      .CW    (CW),
      .AW    (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_accept  (req_accept),
      .addr_a      (addr_a),
      .addr_b      (addr_b),
      .pos         (pos)
   );

   // column sum store
   gmp_column_mem #(
      .DEPTH (MAX_N),
      .AW    (AW),
      .DW    (SUM_W)
   ) u_mem (
      .clock        (clock),
      .rd_en        (req_accept),
      .rd_addr_a    (addr_a),
      .rd_addr_b    (addr_b),
      .rd_data_a_ff (rd_data_a),
      .rd_data_b_ff (rd_data_b),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   // update and result stage
   gmp_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .SUM_W      (SUM_W),
      .AW         (AW)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .req_cell_value   (req_bus.cell_value),
      .req_accept       (req_accept),
      .pos              (pos),
      .addr_a           (addr_a),
      .addr_b           (addr_b),
      .rd_data_a        (rd_data_a),
      .rd_data_b        (rd_data_b),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_path_sum     (rsp_bus.path_sum),
      .rsp_row_index    (rsp_bus.row_index),
      .rsp_column_index (rsp_bus.column_index),
      .rsp_last_of_grid (rsp_bus.last_of_grid)
   );

endmodule
